### hw/rtl/rain_rate_pair_accumulation_defines.svh
// ----------------------------------------------------------------------------
// Rain rate pair accumulation - assertion macros
// Shared helpers for the concurrent checks on the accumulation block.
// ----------------------------------------------------------------------------
`ifndef RAIN_RATE_PAIR_ACCUMULATION_DEFINES_SVH
`define RAIN_RATE_PAIR_ACCUMULATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RRPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RRPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rrpa_pkg.sv
// ----------------------------------------------------------------------------
// Rain rate pair accumulation - package
// Field widths, register indexes and the fixed constants of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpa_pkg;

   localparam int RATE_W    = 16;
   localparam int SUM_W     = 17;
   localparam int SECONDS_W = 32;
   localparam int SPAN_W    = 33;
   localparam int SPANS_W   = 17;   // a valid span is below 2047 minutes
   localparam int MINUTES_W = 11;
   localparam int CAPMM_W   = 10;
   localparam int CAP_W     = 16;
   localparam int CAPX_W    = 29;
   localparam int PROD_W    = 34;
   localparam int NUM_W     = 24;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // two hours in seconds and half of it for rounding
   localparam logic [12:0] TWO_HOURS = 13'd7200;
   localparam logic [34:0] HALF_TWO_HOURS = 35'd3600;

   // depths above this saturate at the largest positive code
   localparam logic [PROD_W-1:0] SAT_LIMIT = 34'd235922400;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'h7FFF;

   // x / 225 == (x * RECIP_225) >> 32 for x below 2**24
   localparam logic [24:0] RECIP_225 = 25'd19088744;

   // floor(mm * 10000 / 254) == (mm * CAP_MULT) >> 30 for mm below 1024
   localparam logic [35:0] CAP_MULT = 36'd42273305000;

   localparam logic [SPANS_W-1:0] RESTART_RESET = 17'd3600;
   localparam logic [SPANS_W-1:0] LIMIT_RESET   = 17'd1800;
   localparam logic [CAP_W-1:0]   CAP_RESET     = 16'd15748;
   localparam logic [CAPX_W-1:0]  CAPX_RESET    = 29'd113385600;
   localparam logic [VALUE_W-1:0] NODATA_RESET  = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEGIN_SECONDS   = 3'd0,
      CSR_END_SECONDS     = 3'd1,
      CSR_RESTART_MINUTES = 3'd2,
      CSR_INTERP_MINUTES  = 3'd3,
      CSR_PERIOD_CAP_MM   = 3'd4,
      CSR_NODATA_CODE     = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/rrpa_req_if.sv
// ----------------------------------------------------------------------------
// Rain rate pair accumulation - request channel
// Valid/ready channel carrying the two rates of one grid bin.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrpa_req_if
   import rrpa_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              first_missing;
   logic [RATE_W-1:0] first_rate;
   logic              second_missing;
   logic [RATE_W-1:0] second_rate;

   modport source (
      output valid, first_missing, first_rate, second_missing, second_rate,
      input  ready
   );

   modport sink (
      input  valid, first_missing, first_rate, second_missing, second_rate,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/rrpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Rain rate pair accumulation - response channel
// Valid/ready channel carrying the accumulation result of one grid bin.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrpa_rsp_if
   import rrpa_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] accum_value;
   logic                      grid_status;
   logic                      missing_period;
   logic signed [SPAN_W-1:0]  missing_seconds;

   modport source (
      output valid, accum_value, grid_status, missing_period, missing_seconds,
      input  ready
   );

   modport sink (
      input  valid, accum_value, grid_status, missing_period, missing_seconds,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/rain_rate_pair_accumulation.sv
// ----------------------------------------------------------------------------
// Rain rate pair accumulation
// Scan-to-scan rain depth per grid bin from two rain rates and the scan times.
// ----------------------------------------------------------------------------
//   channel    direction  handshake           payload
//   req_chan   in         valid/ready         two missing bits, two rates
//   rsp_chan   out        valid/ready         depth, status, flag, seconds
//   csr        in         csr_write_en only   csr_index, csr_wdata
//
// Six register stages: span, classify, multiply, compare and round, divide by
// 225 through a reciprocal multiply, final select. One item per cycle unless
// rsp_chan stalls. Each stage advances when it is empty or the next one
// advances, so bubbles collapse under a stalled output. Synchronous reset
// clears valid bits and loads register defaults; the cap threshold follows
// a cap write in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rain_rate_pair_accumulation
   import rrpa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   rrpa_req_if.sink                   req_chan,
   rrpa_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration, kept in the form the datapath uses
   logic [SECONDS_W-1:0] begin_ff;
   logic [SECONDS_W-1:0] end_ff;
   logic [SPANS_W-1:0]   restart_s_ff;
   logic [SPANS_W-1:0]   limit_s_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [CAPX_W-1:0]    capx_ff;
   logic [VALUE_W-1:0]   nodata_ff;

   logic [SPANS_W-1:0]   minutes_s_in;
   logic [45:0]          cap_prod;
   logic [CAPX_W-1:0]    capx_in;

   assign minutes_s_in = ({6'b0, csr_wdata[MINUTES_W-1:0]} << 6)
                       - ({6'b0, csr_wdata[MINUTES_W-1:0]} << 2);
   assign cap_prod     = {36'b0, csr_wdata[CAPMM_W-1:0]} * {10'b0, CAP_MULT};
   assign capx_in      = {13'b0, cap_ff} * {16'b0, TWO_HOURS};

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_ff     <= '0;
         end_ff       <= '0;
         restart_s_ff <= RESTART_RESET;
         limit_s_ff   <= LIMIT_RESET;
         cap_ff       <= CAP_RESET;
         capx_ff      <= CAPX_RESET;
         nodata_ff    <= NODATA_RESET;
      end else begin
         capx_ff <= capx_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_BEGIN_SECONDS:   begin_ff     <= csr_wdata;
               CSR_END_SECONDS:     end_ff       <= csr_wdata;
               CSR_RESTART_MINUTES: restart_s_ff <= minutes_s_in;
               CSR_INTERP_MINUTES:  limit_s_ff   <= minutes_s_in;
               CSR_PERIOD_CAP_MM:   cap_ff       <= cap_prod[45:30];
               CSR_NODATA_CODE:     nodata_ff    <= csr_wdata[VALUE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !v6_ff || rsp_chan.ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage 1: rate sum and raw span
   logic [SUM_W-1:0]  s1_sum_ff;
   logic              s1_nodata_ff;
   logic [SPAN_W-1:0] s1_span_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sum_ff    <= {1'b0, req_chan.first_rate} + {1'b0, req_chan.second_rate};
         s1_nodata_ff <= req_chan.first_missing || req_chan.second_missing;
         s1_span_ff   <= {1'b0, end_ff} - {1'b0, begin_ff};
      end
   end

   // stage 2: classify the span, clamp to the limit
   logic                s2_invalid_in, s2_clamp_in, span_pos;
   logic [SPAN_W-1:0]   s2_miss_in;
   logic [SPANS_W-1:0]  s2_span_in;
   logic [SUM_W-1:0]    s2_sum_ff;
   logic                s2_nodata_ff, s2_invalid_ff, s2_clamp_ff;
   logic [SPAN_W-1:0]   s2_miss_ff;
   logic [SPANS_W-1:0]  s2_span_ff;

   always_comb begin
      span_pos      = !s1_span_ff[SPAN_W-1] && (s1_span_ff != '0);
      s2_invalid_in = !span_pos
                   || (s1_span_ff[SECONDS_W-1:0] >= {15'b0, restart_s_ff});
      s2_clamp_in   = s1_span_ff[SECONDS_W-1:0] > {15'b0, limit_s_ff};
      s2_span_in    = s2_clamp_in ? limit_s_ff : s1_span_ff[SPANS_W-1:0];
      priority if (s2_invalid_in) begin
         s2_miss_in = s1_span_ff;
      end else if (s2_clamp_in) begin
         s2_miss_in = s1_span_ff - {16'b0, limit_s_ff};
      end else begin
         s2_miss_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_sum_ff     <= s1_sum_ff;
         s2_nodata_ff  <= s1_nodata_ff;
         s2_invalid_ff <= s2_invalid_in;
         s2_clamp_ff   <= s2_clamp_in && !s2_invalid_in;
         s2_miss_ff    <= s2_miss_in;
         s2_span_ff    <= s2_span_in;
      end
   end

   // stage 3: rate sum times span
   logic [PROD_W-1:0] s3_prod_ff;
   logic              s3_nodata_ff, s3_invalid_ff, s3_clamp_ff;
   logic [SPAN_W-1:0] s3_miss_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_prod_ff    <= {17'b0, s2_sum_ff} * {17'b0, s2_span_ff};
         s3_nodata_ff  <= s2_nodata_ff;
         s3_invalid_ff <= s2_invalid_ff;
         s3_clamp_ff   <= s2_clamp_ff;
         s3_miss_ff    <= s2_miss_ff;
      end
   end

   // stage 4: cap and saturation tests, rounding offset, divide by 32
   logic [34:0]       rnd_sum;
   logic [NUM_W-1:0]  s4_num_ff;
   logic              s4_le_cap_ff, s4_sat_ff;
   logic              s4_nodata_ff, s4_invalid_ff, s4_clamp_ff;
   logic [SPAN_W-1:0] s4_miss_ff;

   assign rnd_sum = {1'b0, s3_prod_ff} + HALF_TWO_HOURS;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_num_ff     <= rnd_sum[28:5];
         s4_le_cap_ff  <= s3_prod_ff <= {5'b0, capx_ff};
         s4_sat_ff     <= s3_prod_ff > SAT_LIMIT;
         s4_nodata_ff  <= s3_nodata_ff;
         s4_invalid_ff <= s3_invalid_ff;
         s4_clamp_ff   <= s3_clamp_ff;
         s4_miss_ff    <= s3_miss_ff;
      end
   end

   // stage 5: divide by 225
   logic [48:0]        quot_prod;
   logic [VALUE_W-1:0] s5_quot_ff;
   logic               s5_le_cap_ff, s5_sat_ff;
   logic               s5_nodata_ff, s5_invalid_ff, s5_clamp_ff;
   logic [SPAN_W-1:0]  s5_miss_ff;

   assign quot_prod = {25'b0, s4_num_ff} * {24'b0, RECIP_225};

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_quot_ff    <= quot_prod[47:32];
         s5_le_cap_ff  <= s4_le_cap_ff;
         s5_sat_ff     <= s4_sat_ff;
         s5_nodata_ff  <= s4_nodata_ff;
         s5_invalid_ff <= s4_invalid_ff;
         s5_clamp_ff   <= s4_clamp_ff;
         s5_miss_ff    <= s4_miss_ff;
      end
   end

   // stage 6: final select into the output register
   logic [VALUE_W-1:0] value_in;
   logic [VALUE_W-1:0] s6_value_ff;
   logic               s6_status_ff, s6_flag_ff;
   logic [SPAN_W-1:0]  s6_miss_ff;

   always_comb begin
      priority if (s5_invalid_ff) begin
         value_in = '0;
      end else if (s5_nodata_ff) begin
         value_in = nodata_ff;
      end else if (s5_le_cap_ff) begin
         // step off the no-data code
         value_in = (s5_quot_ff == nodata_ff) ? s5_quot_ff + 16'd1 : s5_quot_ff;
      end else if (s5_sat_ff) begin
         value_in = VALUE_MAX;
      end else begin
         value_in = cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_value_ff  <= value_in;
         s6_status_ff <= s5_invalid_ff;
         s6_flag_ff   <= s5_invalid_ff || s5_clamp_ff;
         s6_miss_ff   <= s5_miss_ff;
      end
   end

   assign rsp_chan.valid           = v6_ff;
   assign rsp_chan.accum_value     = s6_value_ff;
   assign rsp_chan.grid_status     = s6_status_ff;
   assign rsp_chan.missing_period  = s6_flag_ff;
   assign rsp_chan.missing_seconds = s6_miss_ff;

endmodule

`default_nettype wire

### hw/rtl/rrpa_checker.sv
// ----------------------------------------------------------------------------
// Rain rate pair accumulation - port checker
// Watches the response channel for flag consistency and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rain_rate_pair_accumulation_defines.svh"

module rrpa_checker
   import rrpa_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [VALUE_W-1:0] rsp_accum_value,
   input wire logic                      rsp_grid_status,
   input wire logic                      rsp_missing_period,
   input wire logic signed [SPAN_W-1:0]  rsp_missing_seconds
);

   // a stalled item holds
   `RRPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_accum_value) && $stable(rsp_missing_seconds), "response item changed while stalled")

   // an invalid span always flags a missing period
   `RRPA_ASSERT_NOW(a_status_flag, clock, reset, rsp_valid && rsp_grid_status, rsp_missing_period, "invalid span without missing period")

   // an invalid span accumulates nothing: value is zero
   `RRPA_ASSERT_NOW(a_status_zero, clock, reset, rsp_valid && rsp_grid_status, rsp_accum_value == '0, "invalid span with nonzero value")

   // an unflagged period leaves no missing seconds
   `RRPA_ASSERT_NOW(a_flag_seconds, clock, reset, rsp_valid && !rsp_missing_period, rsp_missing_seconds == '0, "missing seconds without flag")

endmodule

bind rain_rate_pair_accumulation rrpa_checker u_rrpa_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_accum_value     (rsp_chan.accum_value),
   .rsp_grid_status     (rsp_chan.grid_status),
   .rsp_missing_period  (rsp_chan.missing_period),
   .rsp_missing_seconds (rsp_chan.missing_seconds)
);

`default_nettype wire
